// ----- sv/sgc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared types and constants for the stepper gate controller.
// ----------------------------------------------------------------------------
package sgc_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_TRAVEL = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_WAIT   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_WAIT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEAVE_HOLD  = 3'd3;

   localparam logic [11:0] FULL_TRAVEL_RST = 12'd1024;
   localparam logic [7:0]  OPEN_WAIT_RST   = 8'd100;
   localparam logic [7:0]  CLOSE_WAIT_RST  = 8'd100;
   localparam logic [7:0]  LEAVE_HOLD_RST  = 8'd10;

   // transaction kinds
   localparam logic KIND_MOTOR  = 1'b0;
   localparam logic KIND_SENSOR = 1'b1;

   // motor phases: idle, then half-step phases one to eight
   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_FIRST  = 4'd1;
   localparam logic [3:0] M_LAST   = 4'd8;

   // sensor states
   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_WATCH   = 2'd1;
   localparam logic [1:0] S_PRESENT = 2'd2;
   localparam logic [1:0] S_LEAVING = 2'd3;

   typedef struct packed {
      logic kind;
      logic car_sensor;
      logic lot_full;
   } req_type;

   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic        warning_lamp;
      logic [11:0] gate_position;
      logic        car_present;
   } rsp_type;

   typedef struct packed {
      logic car_seen;
      logic entrance_mark;
      logic restart_pulse;
   } sen_status_type;

   typedef struct packed {
      logic [11:0] full_travel_steps;
      logic [7:0]  open_wait_ticks;
      logic [7:0]  close_wait_ticks;
   } motor_cfg_type;

   // half-step coil drive pattern per phase
   function automatic logic [3:0] coil_lut(input logic [3:0] phase);
      logic [3:0] pat;
      case (phase)
         4'd1:    pat = 4'h1;
         4'd2:    pat = 4'h3;
         4'd3:    pat = 4'h2;
         4'd4:    pat = 4'h6;
         4'd5:    pat = 4'h4;
         4'd6:    pat = 4'hC;
         4'd7:    pat = 4'h8;
         4'd8:    pat = 4'h9;
         default: pat = 4'h0;
      endcase
      return pat;
   endfunction

endpackage
`default_nettype wire

// ----- sv/sgc_sensor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_sensor
// Car presence machine: idle, watch, present, leaving with hold count.
// ----------------------------------------------------------------------------
module sgc_sensor (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    car,
   input  wire logic [7:0]              leave_hold_ticks,
   output sgc_pkg::sen_status_type      status
);
   import sgc_pkg::*;

   logic [1:0] state_ff, state_in;
   logic [7:0] leave_cnt_ff, leave_cnt_in;
   logic       seen_ff, seen_in;
   logic       mark_ff, mark_in;
   logic       restart_ff, restart_in;

   always_comb begin
      state_in     = state_ff;
      leave_cnt_in = leave_cnt_ff;
      seen_in      = seen_ff;
      mark_in      = mark_ff;
      restart_in   = restart_ff;
      case (state_ff)
         S_IDLE: begin
            leave_cnt_in = 8'd0;
            state_in     = S_WATCH;
         end
         S_WATCH: begin
            restart_in = 1'b0;
            seen_in    = 1'b0;
            if (car) state_in = S_PRESENT;
         end
         S_PRESENT: begin
            seen_in = 1'b1;
            mark_in = 1'b1;
            if (!car) state_in = S_LEAVING;
         end
         default: begin
            mark_in = 1'b0;
            if (leave_cnt_ff < leave_hold_ticks) begin
               leave_cnt_in = leave_cnt_ff + 8'd1;
            end else begin
               leave_cnt_in = 8'd0;
               restart_in   = 1'b1;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         leave_cnt_ff <= 8'd0;
         seen_ff      <= 1'b0;
         mark_ff      <= 1'b0;
         restart_ff   <= 1'b0;
      end else if (step) begin
         state_ff     <= state_in;
         leave_cnt_ff <= leave_cnt_in;
         seen_ff      <= seen_in;
         mark_ff      <= mark_in;
         restart_ff   <= restart_in;
      end
   end

   assign status.car_seen      = seen_ff;
   assign status.entrance_mark = mark_ff;
   assign status.restart_pulse = restart_ff;

endmodule
`default_nettype wire

// ----- sv/sgc_motor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sgc_motor
// Eight-phase half-step sequencer with open/close waits and lamp.
// ----------------------------------------------------------------------------
module sgc_motor (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    lot_full,
   input  wire sgc_pkg::motor_cfg_type  cfg,
   input  wire sgc_pkg::sen_status_type sen,
   output logic [3:0]                   coil,
   output logic                         lamp,
   output logic [11:0]                  position
);
   import sgc_pkg::*;

   logic [3:0]  phase_ff, phase_in;
   logic [11:0] pos_ff, pos_in;
   logic [7:0]  open_cnt_ff, open_cnt_in;
   logic [7:0]  close_cnt_ff, close_cnt_in;
   logic [3:0]  coil_ff, coil_in;
   logic        lamp_ff, lamp_in;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      open_cnt_in  = open_cnt_ff;
      close_cnt_in = close_cnt_ff;
      coil_in      = coil_ff;
      lamp_in      = lamp_ff;
      if (phase_ff == M_IDLE) begin
         pos_in       = 12'd0;
         open_cnt_in  = 8'd0;
         close_cnt_in = 8'd0;
         phase_in     = lot_full ? M_IDLE : M_FIRST;
      end else if (phase_ff <= M_LAST) begin
         // coil follows the phase held at the start of the tick
         coil_in = coil_lut(phase_ff);
         if (lot_full) begin
            phase_in = M_IDLE;
         end else if (sen.car_seen) begin
            if (sen.entrance_mark) begin
               if (phase_ff == M_FIRST && open_cnt_ff < cfg.open_wait_ticks) begin
                  lamp_in     = 1'b1;
                  open_cnt_in = open_cnt_ff + 8'd1;
               end else if (pos_ff != cfg.full_travel_steps) begin
                  if (phase_ff == M_FIRST) lamp_in = 1'b0;
                  pos_in   = pos_ff + 12'd1;
                  phase_in = (phase_ff == M_LAST) ? M_FIRST : phase_ff + 4'd1;
               end
            end else begin
               if (phase_ff == M_FIRST && close_cnt_ff < cfg.close_wait_ticks) begin
                  close_cnt_in = close_cnt_ff + 8'd1;
               end else begin
                  if (pos_ff != 12'd0) begin
                     pos_in   = pos_ff - 12'd1;
                     phase_in = (phase_ff == M_FIRST) ? M_LAST : phase_ff - 4'd1;
                  end
                  if (sen.restart_pulse) phase_in = M_IDLE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= M_IDLE;
         pos_ff       <= 12'd0;
         open_cnt_ff  <= 8'd0;
         close_cnt_ff <= 8'd0;
         coil_ff      <= 4'd0;
         lamp_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         open_cnt_ff  <= open_cnt_in;
         close_cnt_ff <= close_cnt_in;
         coil_ff      <= coil_in;
         lamp_ff      <= lamp_in;
      end
   end

   assign coil     = coil_ff;
   assign lamp     = lamp_ff;
   assign position = pos_ff;

endmodule
`default_nettype wire

// ----- sv/stepper_gate_controller_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_gate_controller_unit
// Barrier gate driver: car presence machine plus half-step stepper sequencer.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | role
//   --------+--------------------------------+------------------------------
//   req     | req_valid/req_ready/req_data   | one tick (motor or sensor)
//   rsp     | rsp_valid/rsp_ready/rsp_data   | coil, lamp, position, mark
//   csr     | csr_wr_en/csr_index/csr_wdata  | register writes, no read-back
//
// Throughput is one transaction per cycle. A request is captured in an input
// register; the tick's state update then runs once the response slot is free
// or being emptied, and the state registers, which hold the response payload,
// load together with rsp_valid, so the response follows the input register.
// A response waiting on rsp_ready freezes the state; the input register still
// takes one more request, after which req_ready drops until the response goes.
// Synchronous reset clears all control state and loads register defaults.
// ----------------------------------------------------------------------------
module stepper_gate_controller_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire sgc_pkg::req_type                    req_data,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output sgc_pkg::rsp_type                         rsp_data,
   // configuration port
   input  wire logic                                csr_wr_en,
   input  wire logic [sgc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [sgc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import sgc_pkg::*;

   // configuration registers
   logic [11:0] full_travel_ff;
   logic [7:0]  open_wait_ff;
   logic [7:0]  close_wait_ff;
   logic [7:0]  leave_hold_ff;

   // input stage
   logic        in_vld_ff;
   req_type     in_data_ff;

   // response stage: valid flag; payload lives in the state registers
   logic        rsp_vld_ff;

   logic        advance;
   logic        motor_step;
   logic        sensor_step;

   motor_cfg_type  motor_cfg;
   sen_status_type sen_status;
   logic [3:0]     coil;
   logic           lamp;
   logic [11:0]    position;

   // a tick runs when the response slot is free or being emptied
   assign advance     = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready   = !in_vld_ff || advance;
   assign motor_step  = advance && (in_data_ff.kind == KIND_MOTOR);
   assign sensor_step = advance && (in_data_ff.kind == KIND_SENSOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_travel_ff <= FULL_TRAVEL_RST;
         open_wait_ff   <= OPEN_WAIT_RST;
         close_wait_ff  <= CLOSE_WAIT_RST;
         leave_hold_ff  <= LEAVE_HOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FULL_TRAVEL: full_travel_ff <= csr_wdata[11:0];
            CSR_OPEN_WAIT:   open_wait_ff   <= csr_wdata[7:0];
            CSR_CLOSE_WAIT:  close_wait_ff  <= csr_wdata[7:0];
            CSR_LEAVE_HOLD:  leave_hold_ff  <= csr_wdata[7:0];
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   assign motor_cfg.full_travel_steps = full_travel_ff;
   assign motor_cfg.open_wait_ticks   = open_wait_ff;
   assign motor_cfg.close_wait_ticks  = close_wait_ff;

   sgc_sensor u_sensor (
      .clock            (clock),
      .reset            (reset),
      .step             (sensor_step),
      .car              (in_data_ff.car_sensor),
      .leave_hold_ticks (leave_hold_ff),
      .status           (sen_status)
   );

   sgc_motor u_motor (
      .clock    (clock),
      .reset    (reset),
      .step     (motor_step),
      .lot_full (in_data_ff.lot_full),
      .cfg      (motor_cfg),
      .sen      (sen_status),
      .coil     (coil),
      .lamp     (lamp),
      .position (position)
   );

   // state only moves on advance, so the payload holds while a response stalls
   assign rsp_valid              = rsp_vld_ff;
   assign rsp_data.coil_pattern  = coil;
   assign rsp_data.warning_lamp  = lamp;
   assign rsp_data.gate_position = position;
   assign rsp_data.car_present   = sen_status.entrance_mark;

endmodule
`default_nettype wire
